[rtl/core/distance_zone_alarm_driver_macros.svh]
// Assertion macros used by the checker of the distance zone alarm driver.
`ifndef DISTANCE_ZONE_ALARM_DRIVER_MACROS_SVH
`define DISTANCE_ZONE_ALARM_DRIVER_MACROS_SVH

// Same-cycle implication, held off while reset is asserted.
`define DZA_ASSERT_IMP(label, clk, rst_n, ante, cons) \
    label: assert property (@(posedge clk) disable iff (!(rst_n)) (ante) |-> (cons)) \
        else $error("dza: same-cycle check failed");

// Next-cycle implication, held off while reset is asserted.
`define DZA_ASSERT_NXT(label, clk, ante, cons, rst_n) \
    label: assert property (@(posedge clk) disable iff (!(rst_n)) (ante) |=> (cons)) \
        else $error("dza: next-cycle check failed");

// Next-cycle implication that is also checked through reset.
`define DZA_ASSERT_NXT_ALWAYS(label, clk, ante, cons) \
    label: assert property (@(posedge clk) (ante) |=> (cons)) \
        else $error("dza: reset check failed");

`endif

[rtl/core/dza_pkg.sv]
// Types and constants of the distance zone alarm driver.
package dza_pkg;

    localparam int DIST_BITS = 10;
    localparam int TIME_BITS = 32;
    localparam int THR_BITS  = 10;
    localparam int PER_BITS  = 16;

    // Compare widths: wide enough for both operands.
    localparam int DCMP_BITS = (DIST_BITS > THR_BITS) ? DIST_BITS : THR_BITS;
    localparam int TCMP_BITS = (TIME_BITS > PER_BITS) ? TIME_BITS : PER_BITS;

    localparam int APB_ADDR_BITS = 5;
    localparam int APB_DATA_BITS = 32;
    localparam int REG_IDX_BITS  = 3;

    // No-echo code; only meaningful when it fits the distance field.
    localparam int                   NO_ECHO_VALUE = 999;
    localparam logic                 NO_ECHO_FITS  = (NO_ECHO_VALUE < (1 << DIST_BITS));
    localparam logic [DIST_BITS-1:0] NO_ECHO_CM    = DIST_BITS'(NO_ECHO_VALUE);

    localparam logic [THR_BITS-1:0] FAR_RESET   = THR_BITS'(30);
    localparam logic [THR_BITS-1:0] NEAR_RESET  = THR_BITS'(10);
    localparam logic [THR_BITS-1:0] CLOSE_RESET = THR_BITS'(5);
    localparam logic [PER_BITS-1:0] SLOW_RESET  = PER_BITS'(500);
    localparam logic [PER_BITS-1:0] FAST_RESET  = PER_BITS'(150);
    localparam logic [PER_BITS-1:0] MUTE_RESET  = PER_BITS'(3000);

    typedef enum logic [REG_IDX_BITS-1:0] {
        REG_FAR   = 3'd0,
        REG_NEAR  = 3'd1,
        REG_CLOSE = 3'd2,
        REG_SLOW  = 3'd3,
        REG_FAST  = 3'd4,
        REG_MUTE  = 3'd5
    } t_reg_idx;

    typedef struct packed {
        logic [THR_BITS-1:0] far_threshold;
        logic [THR_BITS-1:0] near_threshold;
        logic [THR_BITS-1:0] close_threshold;
        logic [PER_BITS-1:0] slow_period_ms;
        logic [PER_BITS-1:0] fast_period_ms;
        logic [PER_BITS-1:0] mute_hold_ms;
    } t_cfg;

    typedef struct packed {
        logic [DIST_BITS-1:0] distance_cm;
        logic [TIME_BITS-1:0] now_ms;
    } t_item;

    typedef struct packed {
        logic green_on;
        logic yellow_on;
        logic red_on;
        logic buzzer_on;
    } t_result;

endpackage

[rtl/core/dza_cfg_regs.sv]
// APB configuration registers of the distance zone alarm driver.
module dza_cfg_regs
    import dza_pkg::*;
(
    input  logic                     i_clk,
    input  logic                     i_rst_n,
    input  logic                     psel,
    input  logic                     penable,
    input  logic                     pwrite,
    input  logic [APB_ADDR_BITS-1:0] paddr,
    input  logic [APB_DATA_BITS-1:0] pwdata,
    output logic [APB_DATA_BITS-1:0] prdata,
    output logic                     pready,
    output t_cfg                     o_cfg
);

    t_cfg     r_cfg;
    t_cfg     n_cfg;
    t_reg_idx idx;
    logic     wr_en;

    assign idx    = t_reg_idx'(paddr[APB_ADDR_BITS-1:2]);
    assign wr_en  = psel && penable && pwrite;
    assign pready = 1'b1;
    assign o_cfg  = r_cfg;

    always_comb begin
        n_cfg = r_cfg;
        if (wr_en) begin
            unique case (idx)
                REG_FAR:   n_cfg.far_threshold   = pwdata[THR_BITS-1:0];
                REG_NEAR:  n_cfg.near_threshold  = pwdata[THR_BITS-1:0];
                REG_CLOSE: n_cfg.close_threshold = pwdata[THR_BITS-1:0];
                REG_SLOW:  n_cfg.slow_period_ms  = pwdata[PER_BITS-1:0];
                REG_FAST:  n_cfg.fast_period_ms  = pwdata[PER_BITS-1:0];
                REG_MUTE:  n_cfg.mute_hold_ms    = pwdata[PER_BITS-1:0];
                default:   n_cfg = r_cfg;
            endcase
        end
    end

    always_comb begin
        unique case (idx)
            REG_FAR:   prdata = APB_DATA_BITS'(r_cfg.far_threshold);
            REG_NEAR:  prdata = APB_DATA_BITS'(r_cfg.near_threshold);
            REG_CLOSE: prdata = APB_DATA_BITS'(r_cfg.close_threshold);
            REG_SLOW:  prdata = APB_DATA_BITS'(r_cfg.slow_period_ms);
            REG_FAST:  prdata = APB_DATA_BITS'(r_cfg.fast_period_ms);
            REG_MUTE:  prdata = APB_DATA_BITS'(r_cfg.mute_hold_ms);
            default:   prdata = '0;
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_cfg.far_threshold   <= FAR_RESET;
            r_cfg.near_threshold  <= NEAR_RESET;
            r_cfg.close_threshold <= CLOSE_RESET;
            r_cfg.slow_period_ms  <= SLOW_RESET;
            r_cfg.fast_period_ms  <= FAST_RESET;
            r_cfg.mute_hold_ms    <= MUTE_RESET;
        end else begin
            r_cfg <= n_cfg;
        end
    end

endmodule

[rtl/core/dza_track.sv]
// Zone decode, blink and mute tracking state of the distance zone alarm driver.
module dza_track
    import dza_pkg::*;
(
    input  logic    i_clk,
    input  logic    i_rst_n,
    input  logic    i_advance,
    input  t_item   i_item,
    input  t_cfg    i_cfg,
    output t_result o_result
);

    logic [DIST_BITS-1:0] r_prev_dist,  n_prev_dist;
    logic [TIME_BITS-1:0] r_unch_since, n_unch_since;
    logic                 r_mute,       n_mute;
    logic [TIME_BITS-1:0] r_last_tog,   n_last_tog;
    logic                 r_phase,      n_phase;

    logic                 echo;
    logic                 same;
    logic [TIME_BITS-1:0] mute_elapsed;
    logic [TIME_BITS-1:0] blink_elapsed;
    logic [DCMP_BITS-1:0] dist_w;
    logic                 zone_far, zone_mid, zone_near, zone_vnear;
    logic [PER_BITS-1:0]  period;
    logic                 toggle;
    logic                 phase_now;
    logic                 mute_now;

    assign echo   = !(NO_ECHO_FITS && (i_item.distance_cm == NO_ECHO_CM));
    assign same   = (i_item.distance_cm == r_prev_dist);
    assign dist_w = DCMP_BITS'(i_item.distance_cm);

    assign mute_elapsed  = i_item.now_ms - r_unch_since;
    assign blink_elapsed = i_item.now_ms - r_last_tog;

    // Zones in decreasing distance order; misordered thresholds fall through.
    assign zone_far   = dist_w > DCMP_BITS'(i_cfg.far_threshold);
    assign zone_mid   = !zone_far && (dist_w > DCMP_BITS'(i_cfg.near_threshold));
    assign zone_near  = !zone_far && !zone_mid
                        && (dist_w > DCMP_BITS'(i_cfg.close_threshold));
    assign zone_vnear = !zone_far && !zone_mid && !zone_near;

    assign period    = zone_mid ? i_cfg.slow_period_ms : i_cfg.fast_period_ms;
    assign toggle    = (zone_mid || zone_near)
                       && (TCMP_BITS'(blink_elapsed) >= TCMP_BITS'(period));
    assign phase_now = toggle ? !r_phase : r_phase;
    assign mute_now  = same ? (r_mute || (TCMP_BITS'(mute_elapsed)
                                          > TCMP_BITS'(i_cfg.mute_hold_ms)))
                            : 1'b0;

    always_comb begin
        n_prev_dist  = r_prev_dist;
        n_unch_since = r_unch_since;
        n_mute       = r_mute;
        n_last_tog   = r_last_tog;
        n_phase      = r_phase;
        if (i_advance && echo) begin
            n_mute  = mute_now;
            n_phase = phase_now;
            if (!same) begin
                n_prev_dist  = i_item.distance_cm;
                n_unch_since = i_item.now_ms;
            end
            if (toggle) begin
                n_last_tog = i_item.now_ms;
            end
        end
    end

    always_comb begin
        o_result.green_on  = echo && zone_far;
        o_result.yellow_on = echo && zone_mid && phase_now;
        o_result.red_on    = echo && ((zone_near && phase_now) || zone_vnear);
        o_result.buzzer_on = (o_result.yellow_on || o_result.red_on) && !mute_now;
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_prev_dist  <= NO_ECHO_CM;
            r_unch_since <= '0;
            r_mute       <= 1'b0;
            r_last_tog   <= '0;
            r_phase      <= 1'b0;
        end else begin
            r_prev_dist  <= n_prev_dist;
            r_unch_since <= n_unch_since;
            r_mute       <= n_mute;
            r_last_tog   <= n_last_tog;
            r_phase      <= n_phase;
        end
    end

endmodule

[rtl/core/distance_zone_alarm_driver.sv]
// Top level of the distance zone alarm driver: input register, tracker, result register.
//
//   channel   direction   handshake                          payload
//   ------------------------------------------------------------------------------------
//   input     in          i_valid / o_stall                  i_distance_cm, i_now_ms
//   result    out         o_valid / i_stall                  o_green_on, o_yellow_on,
//                                                             o_red_on, o_buzzer_on
//   config    in          psel / penable / pwrite / pready   paddr, pwdata, prdata
//
// One word is taken every clock cycle while o_stall is low. A word passes through the input
// register and then the result register, which holds it while i_stall is high.
// The single pass through the tracker sets the rate; its state advances with each word that has an echo.
// Reset (i_rst_n low, synchronous) empties both registers and restores the
// configuration and tracking state. A stall on the result side holds the result
// register; o_stall rises only when the input register is full and cannot drain.
module distance_zone_alarm_driver
    import dza_pkg::*;
(
    input  logic                     i_clk,
    input  logic                     i_rst_n,

    input  logic                     i_valid,
    output logic                     o_stall,
    input  logic [DIST_BITS-1:0]     i_distance_cm,
    input  logic [TIME_BITS-1:0]     i_now_ms,

    output logic                     o_valid,
    input  logic                     i_stall,
    output logic                     o_green_on,
    output logic                     o_yellow_on,
    output logic                     o_red_on,
    output logic                     o_buzzer_on,

    input  logic                     psel,
    input  logic                     penable,
    input  logic                     pwrite,
    input  logic [APB_ADDR_BITS-1:0] paddr,
    input  logic [APB_DATA_BITS-1:0] pwdata,
    output logic [APB_DATA_BITS-1:0] prdata,
    output logic                     pready
);

    t_cfg    cfg;
    t_result result;

    logic    r_s1_valid, n_s1_valid;
    t_item   r_s1_item;
    logic    r_out_valid, n_out_valid;
    t_result r_out;

    logic    out_free;
    logic    s1_move;
    logic    in_take;

    dza_cfg_regs u_cfg_regs (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .psel    (psel),
        .penable (penable),
        .pwrite  (pwrite),
        .paddr   (paddr),
        .pwdata  (pwdata),
        .prdata  (prdata),
        .pready  (pready),
        .o_cfg   (cfg)
    );

    // Tracking state advances only when the input register hands its word on and that word has an echo.
    dza_track u_track (
        .i_clk     (i_clk),
        .i_rst_n   (i_rst_n),
        .i_advance (s1_move),
        .i_item    (r_s1_item),
        .i_cfg     (cfg),
        .o_result  (result)
    );

    // Result register frees up when empty or being taken this cycle.
    assign out_free = !r_out_valid || !i_stall;
    assign s1_move  = r_s1_valid && out_free;
    assign o_stall  = r_s1_valid && !out_free;
    assign in_take  = i_valid && !o_stall;

    assign n_s1_valid  = in_take || (r_s1_valid && !s1_move);
    assign n_out_valid = s1_move || (r_out_valid && i_stall);

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_s1_valid  <= 1'b0;
            r_out_valid <= 1'b0;
        end else begin
            r_s1_valid  <= n_s1_valid;
            r_out_valid <= n_out_valid;
        end
    end

    // Payload registers: load on transfer, hold otherwise.
    always_ff @(posedge i_clk) begin
        if (in_take) begin
            r_s1_item.distance_cm <= i_distance_cm;
            r_s1_item.now_ms      <= i_now_ms;
        end
        if (s1_move) begin
            r_out <= result;
        end
    end

    assign o_valid     = r_out_valid;
    assign o_green_on  = r_out.green_on;
    assign o_yellow_on = r_out.yellow_on;
    assign o_red_on    = r_out.red_on;
    assign o_buzzer_on = r_out.buzzer_on;

endmodule

[rtl/core/dza_checker.sv]
// Port-level checker of the distance zone alarm driver, bound to its top level.
`include "distance_zone_alarm_driver_macros.svh"

module dza_checker (
    input logic i_clk,
    input logic i_rst_n,
    input logic o_valid,
    input logic i_stall,
    input logic o_green_on,
    input logic o_yellow_on,
    input logic o_red_on,
    input logic o_buzzer_on
);

    // Keep a stalled result word valid.
    `DZA_ASSERT_NXT(a_out_hold, i_clk, o_valid && i_stall, o_valid, i_rst_n)

    // At most one LED lit in any result word.
    `DZA_ASSERT_IMP(a_one_led, i_clk, i_rst_n, o_valid, $onehot0({o_green_on, o_yellow_on, o_red_on}))

    // Buzzer only sounds with a warning LED lit.
    `DZA_ASSERT_IMP(a_buzz_warn, i_clk, i_rst_n, o_valid && o_buzzer_on, o_yellow_on || o_red_on)

    // Reset drops any pending result.
    `DZA_ASSERT_NXT_ALWAYS(a_rst_empty, i_clk, !i_rst_n, !o_valid)

endmodule

bind distance_zone_alarm_driver dza_checker u_dza_checker (
    .i_clk       (i_clk),
    .i_rst_n     (i_rst_n),
    .o_valid     (o_valid),
    .i_stall     (i_stall),
    .o_green_on  (o_green_on),
    .o_yellow_on (o_yellow_on),
    .o_red_on    (o_red_on),
    .o_buzzer_on (o_buzzer_on)
);
